// ===== sv/cassette_fsk_run_encoder_defines.svh =====
// Assertion macros shared by the checker of the cassette FSK run encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CASSETTE_FSK_RUN_ENCODER_DEFINES_SVH
`define CASSETTE_FSK_RUN_ENCODER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define CFRE_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent, outside reset.
`define CFRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent holds in the cycle after reset is seen.
`define CFRE_ASSERT_RESET(name, clk, rst, cons, msg) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== sv/cfre_pkg.sv =====
// Package for the cassette FSK run encoder: payload and configuration types,
// register indexes and the fixed constants of the tape format. No dependencies.
`default_nettype none

package cfre_pkg;

   localparam int RESYNC_PERIOD = 16;
   localparam int RESYNC_HALVES = 30;
   localparam int DATA_BITS     = 8;

   localparam int PHASE_W    = (RESYNC_PERIOD > 2) ? $clog2(RESYNC_PERIOD) : 1;
   localparam int BIT_IDX_W  = $clog2(DATA_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HALF_TICKS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HALF_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PILOT_PAIRS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_PAIRS      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_BITS       = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_start;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic        start_level;
      logic [23:0] half_ticks;
      logic [16:0] run_count;
      logic        block_done;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] zero_half_ticks;
      logic [15:0] one_half_ticks;
      logic [23:0] silence_ticks;
      logic [15:0] pilot_pairs;
      logic [15:0] tail_pairs;
      logic [3:0]  stop_bits;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_start;
      logic       block_end;
      logic       resync;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/cfre_front.sv =====
// Front end of the cassette FSK run encoder: accepts bytes, tracks the byte
// phase within a block and classifies each byte into a job. Uses cfre_pkg.
`default_nettype none

module cfre_front
   import cfre_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_job
);

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W-1:0] phase_base;
   logic               resync;

   assign req_ready  = !queue_full;
   assign push       = req_valid && req_ready;
   assign phase_base = req_data.block_start ? '0 : phase_ff;
   assign resync     = (phase_base == PHASE_W'(RESYNC_PERIOD - 1));

   always_comb begin
      phase_in = phase_ff;
      if (push) begin
         phase_in = resync ? '0 : phase_base + PHASE_W'(1);
      end
   end

   always_comb begin
      push_job.data_byte   = req_data.data_byte;
      push_job.block_start = req_data.block_start;
      push_job.block_end   = req_data.block_end;
      push_job.resync      = resync;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfre_queue.sv =====
// Short job queue between the front and back ends of the cassette FSK run
// encoder, held in registers. Uses cfre_pkg.
`default_nettype none

module cfre_queue
   import cfre_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head
);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cfre_back.sv =====
// Back end of the cassette FSK run encoder: steps through the runs of one job,
// one run per cycle when not stalled, into a result register. Uses cfre_pkg.
`default_nettype none

module cfre_back
   import cfre_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    head_valid,
   input  wire job_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [2:0] STEP_SILENCE = 3'd0;
   localparam logic [2:0] STEP_PILOT   = 3'd1;
   localparam logic [2:0] STEP_START   = 3'd2;
   localparam logic [2:0] STEP_DATA    = 3'd3;
   localparam logic [2:0] STEP_STOP    = 3'd4;
   localparam logic [2:0] STEP_TAIL    = 3'd5;

   logic                 busy_ff;
   logic                 busy_in;
   logic [2:0]           step_ff;
   logic [2:0]           step_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff;
   logic [BIT_IDX_W-1:0] bit_idx_in;
   job_type              job_ff;
   logic                 valid_ff;
   logic                 valid_in;
   rsp_type              out_ff;
   rsp_type              run;
   logic                 emit;
   logic                 has_tail;
   logic [15:0]          pilot_eff;
   logic [3:0]           stop_eff;
   logic [16:0]          stop_count;

   assign pop       = !busy_ff && head_valid;
   assign emit      = busy_ff && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;
   assign has_tail  = job_ff.block_end && (cfg.tail_pairs != '0);
   assign pilot_eff = (cfg.pilot_pairs == '0) ? 16'd1 : cfg.pilot_pairs;
   assign stop_eff  = (cfg.stop_bits == '0) ? 4'd1 : cfg.stop_bits;
   assign stop_count = 17'({stop_eff, 2'b00})
                     + (job_ff.resync ? 17'(RESYNC_HALVES) : 17'd0);

   always_comb begin
      run             = '0;
      busy_in         = busy_ff;
      step_in         = step_ff;
      bit_idx_in      = bit_idx_ff;
      case (step_ff)
         STEP_SILENCE: begin
            run.half_ticks = cfg.silence_ticks;
            run.run_count  = 17'd1;
            step_in        = STEP_PILOT;
         end
         STEP_PILOT: begin
            run.start_level = 1'b1;
            run.half_ticks  = 24'(cfg.one_half_ticks);
            run.run_count   = 17'({pilot_eff, 1'b0}) - 17'd1;
            step_in         = STEP_START;
         end
         STEP_START: begin
            run.half_ticks = 24'(cfg.zero_half_ticks);
            run.run_count  = 17'd2;
            step_in        = STEP_DATA;
            bit_idx_in     = '0;
         end
         STEP_DATA: begin
            if (job_ff.data_byte[bit_idx_ff]) begin
               run.half_ticks = 24'(cfg.one_half_ticks);
               run.run_count  = 17'd4;
            end else begin
               run.half_ticks = 24'(cfg.zero_half_ticks);
               run.run_count  = 17'd2;
            end
            if (bit_idx_ff == BIT_IDX_W'(DATA_BITS - 1)) begin
               step_in = STEP_STOP;
            end else begin
               bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
            end
         end
         STEP_STOP: begin
            run.half_ticks = 24'(cfg.one_half_ticks);
            run.run_count  = stop_count;
            if (has_tail) begin
               step_in = STEP_TAIL;
            end else begin
               run.last       = 1'b1;
               run.block_done = job_ff.block_end;
               busy_in        = 1'b0;
            end
         end
         STEP_TAIL: begin
            run.half_ticks = 24'(cfg.one_half_ticks);
            run.run_count  = 17'({cfg.tail_pairs, 1'b0}) - 17'd1;
            run.last       = 1'b1;
            run.block_done = 1'b1;
            busy_in        = 1'b0;
         end
         default: begin
            busy_in = 1'b0;
         end
      endcase
      if (!emit) begin
         busy_in    = busy_ff;
         step_in    = step_ff;
         bit_idx_in = bit_idx_ff;
      end
      if (pop) begin
         busy_in = 1'b1;
         step_in = head.block_start ? STEP_SILENCE : STEP_START;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ff    <= STEP_START;
         bit_idx_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         step_ff    <= step_in;
         bit_idx_ff <= bit_idx_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head;
      end
      if (emit) begin
         out_ff <= run;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cassette_fsk_run_encoder.sv =====
// Cassette FSK run encoder: tape bytes in, square-wave runs out.
// The request channel takes one byte with block start and end flags per
// transaction. The response channel gives one run per transaction: start
// level, half-period length in ticks, half-period count, block done and a
// last flag on the final run of each byte. Registers are written through the
// csr port and should only change while the block is idle.
// A request is registered in the job queue, then loaded into the run
// sequencer; its first run is then registered in the result register.
// Runs leave one per cycle while the receiver takes them, with a load step
// per byte; no new byte enters the sequencer before its last run is made.
// A two-entry job queue lets the request side run ahead by two bytes.
// When the receiver stalls, the result register holds and the sequencer
// waits; requests are taken until the queue fills.
// Reset clears the queue, the sequencer, the byte phase and loads the
// registers with their default values.
// Uses cfre_pkg, cfre_front, cfre_queue and cfre_back.
`default_nettype none

module cassette_fsk_run_encoder
   import cfre_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ZERO_HALF_TICKS: cfg_in.zero_half_ticks = csr_wdata[15:0];
            CSR_ONE_HALF_TICKS:  cfg_in.one_half_ticks  = csr_wdata[15:0];
            CSR_SILENCE_TICKS:   cfg_in.silence_ticks   = csr_wdata[23:0];
            CSR_PILOT_PAIRS:     cfg_in.pilot_pairs     = csr_wdata[15:0];
            CSR_TAIL_PAIRS:      cfg_in.tail_pairs      = csr_wdata[15:0];
            CSR_STOP_BITS:       cfg_in.stop_bits       = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_half_ticks <= 16'd1664;
         cfg_ff.one_half_ticks  <= 16'd832;
         cfg_ff.silence_ticks   <= 24'd0;
         cfg_ff.pilot_pairs     <= 16'd9600;
         cfg_ff.tail_pairs      <= 16'd24;
         cfg_ff.stop_bits       <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   cfre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   cfre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/cfre_checker.sv =====
// Port-level checker for the cassette FSK run encoder and its bind to the
// top level. Uses cfre_pkg and cassette_fsk_run_encoder_defines.svh.
`default_nettype none
`include "cassette_fsk_run_encoder_defines.svh"

module cfre_checker
   import cfre_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `CFRE_ASSERT_RESET(a_idle_after_reset, clock, reset, !rsp_valid, "result after reset")
   `CFRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `CFRE_ASSERT_ALWAYS(a_count_nonzero, clock, reset, !rsp_valid || (rsp_data.run_count != '0), "empty run")
   `CFRE_ASSERT_ALWAYS(a_done_is_last, clock, reset, !rsp_valid || !rsp_data.block_done || rsp_data.last, "block done without last")

endmodule

bind cassette_fsk_run_encoder cfre_checker u_cfre_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== verif/tb_cassette_fsk_run_encoder.sv =====
// Self-checking testbench for cassette_fsk_run_encoder: drives tape bytes, predicts
// the runs of half-periods for each byte and checks every response transaction.
// Depends on cfre_pkg and the cassette_fsk_run_encoder RTL.
`timescale 1ns / 1ps

module tb_cassette_fsk_run_encoder;
   import cfre_pkg::*;

   localparam int LONG_HOLD_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   req_type                pending_bytes[$];
   rsp_type                expected_runs[$];
   cfg_type                shadow_cfg;
   logic [PHASE_W-1:0]     byte_phase_model = '0;
   rsp_type                want_run;
   int                     mismatch_count = 0;
   int                     idle_pct = 0;
   int                     send_gap = 0;
   int                     stall_left = 0;
   int                     hold_left = 0;
   int                     hold_token = 0;
   int                     hold_seen = 0;

   cassette_fsk_run_encoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic rsp_type make_run(input logic level, input logic [23:0] ticks,
                                        input logic [16:0] count);
      rsp_type run;
      run.start_level = level;
      run.half_ticks  = ticks;
      run.run_count   = count;
      run.block_done  = 1'b0;
      run.last        = 1'b0;
      return run;
   endfunction

   function automatic void encode_byte(input req_type item);
      rsp_type     run;
      logic [16:0] pairs;
      logic [16:0] count;
      logic [3:0]  stops;
      if (item.block_start) begin
         pairs = (shadow_cfg.pilot_pairs == 16'd0) ? 17'd1 : {1'b0, shadow_cfg.pilot_pairs};
         byte_phase_model = '0;
         expected_runs.push_back(make_run(1'b0, shadow_cfg.silence_ticks, 17'd1));
         expected_runs.push_back(make_run(1'b1, {8'd0, shadow_cfg.one_half_ticks},
                                          {pairs[15:0], 1'b0} - 17'd1));
      end
      expected_runs.push_back(make_run(1'b0, {8'd0, shadow_cfg.zero_half_ticks}, 17'd2));
      for (int i = 0; i < DATA_BITS; i++) begin
         if (item.data_byte[i])
            expected_runs.push_back(make_run(1'b0, {8'd0, shadow_cfg.one_half_ticks}, 17'd4));
         else
            expected_runs.push_back(make_run(1'b0, {8'd0, shadow_cfg.zero_half_ticks}, 17'd2));
      end
      if (int'(byte_phase_model) + 1 >= RESYNC_PERIOD)
         byte_phase_model = '0;
      else
         byte_phase_model = byte_phase_model + 1'b1;
      stops = (shadow_cfg.stop_bits == 4'd0) ? 4'd1 : shadow_cfg.stop_bits;
      count = {11'd0, stops, 2'b00};
      if (byte_phase_model == '0)
         count = count + 17'(RESYNC_HALVES);
      expected_runs.push_back(make_run(1'b0, {8'd0, shadow_cfg.one_half_ticks}, count));
      if (item.block_end && shadow_cfg.tail_pairs != 16'd0)
         expected_runs.push_back(make_run(1'b0, {8'd0, shadow_cfg.one_half_ticks},
                                          {shadow_cfg.tail_pairs, 1'b0} - 17'd1));
      run = expected_runs.pop_back();
      run.block_done = item.block_end;
      run.last = 1'b1;
      expected_runs.push_back(run);
   endfunction

   // Request driver: holds the payload until accepted, with random gaps between bytes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            encode_byte(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               send_gap <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected run transaction: level %0d ticks %0d count %0d",
                   rsp_data.start_level, rsp_data.half_ticks, rsp_data.run_count);
            mismatch_count <= mismatch_count + 1;
         end else begin
            want_run = expected_runs.pop_front();
            if (rsp_data !== want_run) begin
               if (rsp_data.start_level !== want_run.start_level)
                  $error("start_level: expected %0d, actual %0d",
                         want_run.start_level, rsp_data.start_level);
               if (rsp_data.half_ticks !== want_run.half_ticks)
                  $error("half_ticks: expected %0d, actual %0d",
                         want_run.half_ticks, rsp_data.half_ticks);
               if (rsp_data.run_count !== want_run.run_count)
                  $error("run_count: expected %0d, actual %0d",
                         want_run.run_count, rsp_data.run_count);
               if (rsp_data.block_done !== want_run.block_done)
                  $error("block_done: expected %0d, actual %0d",
                         want_run.block_done, rsp_data.block_done);
               if (rsp_data.last !== want_run.last)
                  $error("last: expected %0d, actual %0d", want_run.last, rsp_data.last);
               mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_ZERO_HALF_TICKS: shadow_cfg.zero_half_ticks = value[15:0];
         CSR_ONE_HALF_TICKS:  shadow_cfg.one_half_ticks = value[15:0];
         CSR_SILENCE_TICKS:   shadow_cfg.silence_ticks = value;
         CSR_PILOT_PAIRS:     shadow_cfg.pilot_pairs = value[15:0];
         CSR_TAIL_PAIRS:      shadow_cfg.tail_pairs = value[15:0];
         CSR_STOP_BITS:       shadow_cfg.stop_bits = value[3:0];
         default: ;
      endcase
   endtask

   task automatic write_all_csr(input logic [23:0] zero_v, input logic [23:0] one_v,
                                input logic [23:0] silence_v, input logic [23:0] pilot_v,
                                input logic [23:0] tail_v, input logic [23:0] stop_v);
      write_csr(CSR_ZERO_HALF_TICKS, zero_v);
      write_csr(CSR_ONE_HALF_TICKS, one_v);
      write_csr(CSR_SILENCE_TICKS, silence_v);
      write_csr(CSR_PILOT_PAIRS, pilot_v);
      write_csr(CSR_TAIL_PAIRS, tail_v);
      write_csr(CSR_STOP_BITS, stop_v);
      @(negedge clock);
   endtask

   // Register values are mostly random, sometimes all zeros or all ones in the field.
   function automatic logic [23:0] pick_reg_value(input int width);
      logic [23:0] value;
      logic [23:0] mask;
      int          pick;
      value = 24'($urandom);
      mask = 24'((32'h1 << width) - 1);
      pick = $urandom_range(0, 7);
      if (pick == 0)
         value = value & ~mask;
      else if (pick == 1)
         value = value | mask;
      return value;
   endfunction

   task automatic push_byte(input logic [7:0] data, input logic start, input logic stop);
      req_type item;
      item.data_byte = data;
      item.block_start = start;
      item.block_end = stop;
      pending_bytes.push_back(item);
   endtask

   // Mostly well-formed blocks; a few bytes get broken start and end flags.
   task automatic add_random_bytes(input int total);
      int made;
      int len;
      logic start;
      logic stop;
      made = 0;
      while (made < total) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
         for (int j = 0; j < len && made < total; j++) begin
            start = (j == 0);
            stop = (j == len - 1) || (made == total - 1);
            if ($urandom_range(0, 9) == 0) begin
               start = 1'($urandom_range(0, 1));
               stop = 1'($urandom_range(0, 1));
            end
            push_byte(8'($urandom), start, stop);
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_runs.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [7:0] corner_bytes[6];
      int         idle_choices[6];
      corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};
      idle_choices = '{20, 0, 35, 10, 25, 0};
      shadow_cfg.zero_half_ticks = 16'd1664;
      shadow_cfg.one_half_ticks = 16'd832;
      shadow_cfg.silence_ticks = 24'd0;
      shadow_cfg.pilot_pairs = 16'd9600;
      shadow_cfg.tail_pairs = 16'd24;
      shadow_cfg.stop_bits = 4'd3;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 20;
      push_byte(8'h5A, 1'b1, 1'b1);
      for (int i = 0; i < 17; i++)
         push_byte((i < 6) ? corner_bytes[i] : 8'($urandom), i == 0, i == 16);
      push_byte(8'h12, 1'b0, 1'b0);
      push_byte(8'h34, 1'b0, 1'b1);
      wait_drained();

      write_all_csr('0, '0, '0, '0, '0, '0);
      push_byte(8'hA5, 1'b1, 1'b1);
      push_byte(8'h3C, 1'b0, 1'b1);
      wait_drained();

      write_all_csr('1, '1, '1, '1, '1, '1);
      push_byte(8'hFF, 1'b1, 1'b1);
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'h81, 1'b0, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         write_all_csr(pick_reg_value(16), pick_reg_value(16), pick_reg_value(24),
                       pick_reg_value(16), pick_reg_value(16), pick_reg_value(4));
         idle_pct = idle_choices[phase];
         if (phase == 2)
            hold_token = hold_token + 1;
         add_random_bytes(59);
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_runs.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cfre_pkg.sv
sv/cfre_front.sv
sv/cfre_queue.sv
sv/cfre_back.sv
sv/cassette_fsk_run_encoder.sv
sv/cfre_checker.sv
verif/tb_cassette_fsk_run_encoder.sv
